@@ hw/rtl/rgbpbe_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbpbe_pkg
// Shared types and constants for the RGB pixel buffer engine.
// ----------------------------------------------------------------------------
package rgbpbe_pkg;

  localparam int PIXELS_DEF = 256;
  localparam int POS_W      = 10;
  localparam int CH_W       = 8;
  localparam int PCT_W      = 7;
  localparam int PX_W       = 3 * CH_W;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // x / 100 == (x * 5243) >> 19 for every x below 43699
  localparam int PROD_W   = CH_W + PCT_W;
  localparam int RECIP_W  = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SH = 19;
  localparam int QPROD_W  = PROD_W + RECIP_W;

  typedef enum logic [2:0] {
    CMD_SET       = 3'd0,
    CMD_GET       = 3'd1,
    CMD_OR        = 3'd2,
    CMD_XOR       = 3'd3,
    CMD_DIM       = 3'd4,
    CMD_CLEAR     = 3'd5,
    CMD_FILL      = 3'd6,
    CMD_CLEAR_ALL = 3'd7
  } cmd_e;

  typedef enum logic {
    STAT_OK    = 1'b0,
    STAT_RANGE = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MOD,
    ST_SCALE,
    ST_SWEEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [POS_W-1:0] position;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [PCT_W-1:0] dim_percent;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } rsp_t;

endpackage

@@ hw/rtl/rgb_pixel_buffer_engine_top.sv @@
// ----------------------------------------------------------------------------
// rgb_pixel_buffer_engine_top
// Frame store of PIXELS RGB pixels driven by set/get/merge/dim/clear/fill commands.
// ----------------------------------------------------------------------------
// One request is worked at a time against a pixel memory with one write port
// and one registered read port. Set, get, OR, XOR and clear-pixel go through
// accept and read, modify and write back, and hand to the response register;
// dim also has a scale step, as the per-channel multiply by the kept percent
// is registered before the divide-by-100 reciprocal multiply. Fill-all and
// clear-all write one pixel a cycle. Out-of-range requests go from accept
// straight to the response register. After reset the store is swept to zero,
// during which no request is accepted. A new request may be accepted while the
// previous response still waits in the response register.
module rgb_pixel_buffer_engine_top #(
  parameter int PIXELS = rgbpbe_pkg::PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  rgbpbe_pkg::req_t   req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rgbpbe_pkg::rsp_t   rsp
);
  import rgbpbe_pkg::*;

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(PIXELS - 1);
  localparam logic [POS_W:0]   POS_LIMIT = (POS_W + 1)'(PIXELS);

  state_e state, state_next;

  req_t              cur;
  rsp_t              res;
  logic [PCT_W-1:0]  keep;
  logic [AW-1:0]     cnt;
  logic [PROD_W-1:0] prod_r, prod_g, prod_b;

  logic       accept;
  logic       in_range;
  logic       is_sweep_cmd;
  logic       rsp_load;
  logic       mem_we;
  logic [AW-1:0] mem_waddr;
  pixel_t     mem_wdata;
  logic       mem_re;
  pixel_t     rd_px;
  pixel_t     mod_px;
  pixel_t     dim_px;
  logic [PCT_W-1:0] pct_clamped;
  logic [QPROD_W-1:0] q_r, q_g, q_b;

  rgbpbe_store #(
    .DEPTH (PIXELS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (req.position[AW-1:0]),
    .rdata (rd_px)
  );

  assign accept       = req_valid && req_ready;
  assign in_range     = {1'b0, req.position} < POS_LIMIT;
  assign is_sweep_cmd = (req.cmd == CMD_FILL) || (req.cmd == CMD_CLEAR_ALL);
  assign pct_clamped  = (req.dim_percent > PCT_FULL) ? PCT_FULL : req.dim_percent;

  // single-pixel modify for everything but dim
  always_comb begin
    case (cur.cmd)
      CMD_SET:   mod_px = '{red: cur.red, green: cur.green, blue: cur.blue};
      CMD_OR:    mod_px = rd_px | pixel_t'({cur.red, cur.green, cur.blue});
      CMD_XOR:   mod_px = rd_px ^ pixel_t'({cur.red, cur.green, cur.blue});
      CMD_CLEAR: mod_px = '0;
      default:   mod_px = rd_px;
    endcase
  end

  assign q_r = QPROD_W'(prod_r) * QPROD_W'(RECIP_100);
  assign q_g = QPROD_W'(prod_g) * QPROD_W'(RECIP_100);
  assign q_b = QPROD_W'(prod_b) * QPROD_W'(RECIP_100);
  assign dim_px = '{red:   q_r[RECIP_SH +: CH_W],
                    green: q_g[RECIP_SH +: CH_W],
                    blue:  q_b[RECIP_SH +: CH_W]};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:  if (cnt == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (is_sweep_cmd)   state_next = ST_SWEEP;
          else if (!in_range) state_next = ST_DONE;
          else                state_next = ST_MOD;
        end
      end
      ST_MOD:   state_next = (cur.cmd == CMD_DIM) ? ST_SCALE : ST_DONE;
      ST_SCALE: state_next = ST_DONE;
      ST_SWEEP: if (cnt == LAST_ADDR) state_next = ST_DONE;
      ST_DONE:  if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default:  state_next = ST_INIT;
    endcase
  end

  // outputs of the control
  always_comb begin
    req_ready = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = '0;
    rsp_load  = 1'b0;
    case (state)
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        mem_re    = req_valid;
      end
      ST_MOD: begin
        if (cur.cmd != CMD_DIM) begin
          mem_we    = 1'b1;
          mem_waddr = cur.position[AW-1:0];
          mem_wdata = mod_px;
        end
      end
      ST_SCALE: begin
        mem_we    = 1'b1;
        mem_waddr = cur.position[AW-1:0];
        mem_wdata = dim_px;
      end
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_wdata = '{red: res.out_red, green: res.out_green, blue: res.out_blue};
      end
      ST_DONE: begin
        rsp_load = !rsp_valid || rsp_ready;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT || state == ST_SWEEP) begin
        cnt <= cnt + AW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= req;
      keep <= PCT_FULL - pct_clamped;
      if (is_sweep_cmd) begin
        res.status <= STAT_OK;
        if (req.cmd == CMD_FILL) begin
          res.out_red   <= req.red;
          res.out_green <= req.green;
          res.out_blue  <= req.blue;
        end else begin
          res.out_red   <= '0;
          res.out_green <= '0;
          res.out_blue  <= '0;
        end
      end else begin
        res <= '{status: STAT_RANGE, out_red: '0, out_green: '0, out_blue: '0};
      end
    end else if (state == ST_MOD && cur.cmd != CMD_DIM) begin
      res <= '{status: STAT_OK, out_red: mod_px.red, out_green: mod_px.green,
               out_blue: mod_px.blue};
    end else if (state == ST_SCALE) begin
      res <= '{status: STAT_OK, out_red: dim_px.red, out_green: dim_px.green,
               out_blue: dim_px.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MOD) begin
      prod_r <= PROD_W'(rd_px.red)   * PROD_W'(keep);
      prod_g <= PROD_W'(rd_px.green) * PROD_W'(keep);
      prod_b <= PROD_W'(rd_px.blue)  * PROD_W'(keep);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

  // store is never written in the cycle a request is taken
  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !req_ready)
    else $error("memory write while accepting a request");

  // a range error carries a black colour
  a_error_black: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STAT_RANGE |->
      rsp.out_red == '0 && rsp.out_green == '0 && rsp.out_blue == '0)
    else $error("range error response with nonzero colour");

  // no response appears during the reset clearing pass
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_INIT |-> !rsp_valid && !req_ready)
    else $error("activity during clearing pass");

  // scale always follows a dim read
  a_scale_after_mod: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCALE |-> $past(state) == ST_MOD && cur.cmd == CMD_DIM)
    else $error("scale state without a dim read");

endmodule

@@ hw/rtl/rgbpbe_store.sv @@
// ----------------------------------------------------------------------------
// rgbpbe_store
// Pixel frame store: single write port, one registered read port.
// ----------------------------------------------------------------------------
module rgbpbe_store #(
  parameter int DEPTH = rgbpbe_pkg::PIXELS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  rgbpbe_pkg::pixel_t     wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output rgbpbe_pkg::pixel_t     rdata
);
  import rgbpbe_pkg::*;

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ test/rgb_pixel_buffer_engine_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pixel_buffer_engine_top_test
// Self-checking bench for the RGB pixel buffer engine.
// ----------------------------------------------------------------------------
// A shadow copy of the frame store predicts the status and colour of every
// accepted request. Responses are compared in order against that prediction.
// Stimulus is a short directed pass over every command, then random commands
// aimed mostly at a few hot pixels so that merges and dims pile up. Requests
// go out in bursts with gaps, the response side stalls in changing patterns,
// and the sender drains every outstanding response from time to time.
// ----------------------------------------------------------------------------
module rgb_pixel_buffer_engine_top_test;
  import rgbpbe_pkg::*;

  localparam int PIXELS      = PIXELS_DEF;
  localparam int RANDOM_REQS = 1800;
  localparam int IDLE_LIMIT  = 5000;
  localparam int SHOW_LIMIT  = 10;

  typedef struct {
    req_t req;
    bit   drain_first;  // hold off until every response is back
  } pending_t;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  pending_t pending_requests[$];
  rsp_t     expected_colors[$];
  pixel_t   frame_shadow[PIXELS];

  logic     req_taken  = 1'b0;
  int       burst_left = 1;
  int       gap_left   = 0;
  rx_mode_e rx_mode    = RX_ALWAYS;
  int       rx_left    = 0;
  int       rx_count   = 0;
  int       idle_count = 0;
  int       fail_count = 0;

  rgb_pixel_buffer_engine_top #(
    .PIXELS(PIXELS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the frame store: applies one request, returns its response.
  function automatic rsp_t apply_pixel_command(req_t r);
    rsp_t   res;
    pixel_t px;
    int     keep;
    keep = (r.dim_percent > PCT_FULL) ? 0 : int'(PCT_FULL) - int'(r.dim_percent);
    res.status = STAT_OK;
    px = '0;
    if (r.cmd == CMD_FILL || r.cmd == CMD_CLEAR_ALL) begin
      if (r.cmd == CMD_FILL) begin
        px = {r.red, r.green, r.blue};
      end
      foreach (frame_shadow[i]) frame_shadow[i] = px;
    end else if (r.position >= PIXELS) begin
      res.status = STAT_RANGE;
    end else begin
      px = frame_shadow[r.position];
      case (r.cmd)
        CMD_SET: begin
          px = {r.red, r.green, r.blue};
        end
        CMD_OR: begin
          px = px | {r.red, r.green, r.blue};
        end
        CMD_XOR: begin
          px = px ^ {r.red, r.green, r.blue};
        end
        CMD_DIM: begin
          px.red   = 8'((int'(px.red) * keep) / int'(PCT_FULL));
          px.green = 8'((int'(px.green) * keep) / int'(PCT_FULL));
          px.blue  = 8'((int'(px.blue) * keep) / int'(PCT_FULL));
        end
        CMD_CLEAR: begin
          px = '0;
        end
        default: begin
        end
      endcase
      frame_shadow[r.position] = px;
    end
    res.out_red   = px.red;
    res.out_green = px.green;
    res.out_blue  = px.blue;
    return res;
  endfunction

  task automatic report_failure(string what, rsp_t want, rsp_t got);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) begin
      $display("%0t %s: expected st=%0d rgb=%02h%02h%02h, got st=%0d rgb=%02h%02h%02h",
               $realtime, what, want.status, want.out_red, want.out_green, want.out_blue,
               got.status, got.out_red, got.out_green, got.out_blue);
    end
  endtask

  task automatic queue_request(cmd_e c, int pos, int r, int g, int b, int pct,
                               bit drain = 1'b0);
    pending_t p;
    p.req.cmd         = c;
    p.req.position    = POS_W'(pos);
    p.req.red         = CH_W'(r);
    p.req.green       = CH_W'(g);
    p.req.blue        = CH_W'(b);
    p.req.dim_percent = PCT_W'(pct);
    p.drain_first     = drain;
    pending_requests.push_back(p);
  endtask

  function automatic int pick_channel();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return 0;
    if (roll == 1) return 8'hff;
    return $urandom_range(0, 255);
  endfunction

  // Request driver: new payload only after the previous one was taken.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!(req_valid && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending_requests.size() == 0 ||
                   (pending_requests[0].drain_first && expected_colors.size() != 0)) begin
        req_valid <= 1'b0;
      end else begin
        req       <= pending_requests[0].req;
        req_valid <= 1'b1;
        pending_requests.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Response-side backpressure, switching pattern now and then.
  always @(negedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(32, 255);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS:   rsp_ready <= 1'b1;
      RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
      default:     rsp_ready <= (rx_count[2:0] != 3'd0);
    endcase
  end

  // Monitor: predict on request accept, check on response accept.
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      req_taken  <= 1'b0;
      idle_count <= 0;
    end else begin
      req_taken <= req_valid && req_ready;
      if (rsp_valid && rsp_ready) begin
        if (expected_colors.size() == 0) begin
          report_failure("unexpected response", '0, rsp);
        end else begin
          want = expected_colors.pop_front();
          if (rsp.status !== want.status || rsp.out_red !== want.out_red ||
              rsp.out_green !== want.out_green || rsp.out_blue !== want.out_blue) begin
            report_failure("response mismatch", want, rsp);
          end
        end
      end
      if (req_valid && req_ready) begin
        expected_colors.push_back(apply_pixel_command(req));
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  initial begin : stimulus
    int c;
    int p;
    int pos;
    cmd_e op;
    foreach (frame_shadow[i]) frame_shadow[i] = '0;

    // directed
    queue_request(CMD_GET, 0, 0, 0, 0, 0);
    queue_request(CMD_GET, PIXELS - 1, 8'hff, 8'hff, 8'hff, 127);
    queue_request(CMD_SET, 0, 8'hff, 8'hff, 8'hff, 0);
    queue_request(CMD_SET, PIXELS - 1, 8'hff, 8'h00, 8'ha5, 0);
    queue_request(CMD_OR, 0, 0, 0, 0, 0);
    queue_request(CMD_OR, PIXELS - 1, 8'h0f, 8'hf0, 8'h00, 0);
    queue_request(CMD_XOR, 0, 8'hff, 8'h00, 8'h55, 0);
    queue_request(CMD_XOR, 0, 8'hff, 8'h00, 8'h55, 0);
    queue_request(CMD_DIM, 0, 0, 0, 0, 0);
    queue_request(CMD_DIM, 0, 0, 0, 0, 50);
    queue_request(CMD_DIM, PIXELS - 1, 0, 0, 0, 127);
    queue_request(CMD_SET, 5, 8'hff, 8'hff, 8'hff, 0);
    queue_request(CMD_DIM, 5, 0, 0, 0, 101);
    queue_request(CMD_SET, 6, 8'hff, 8'h80, 8'h7f, 0);
    queue_request(CMD_DIM, 6, 0, 0, 0, 1);
    queue_request(CMD_DIM, 6, 0, 0, 0, 99);
    queue_request(CMD_CLEAR, 6, 8'hff, 8'hff, 8'hff, 100);
    // out of range for every single-pixel command
    for (c = int'(CMD_SET); c <= int'(CMD_CLEAR); c++) begin
      queue_request(cmd_e'(c), (c % 2 == 0) ? PIXELS : 1023, 8'hff, 8'hff, 8'hff, 100);
    end
    queue_request(CMD_FILL, 1023, 8'h12, 8'h34, 8'h56, 127, 1'b1);
    queue_request(CMD_GET, 100, 0, 0, 0, 0);
    queue_request(CMD_CLEAR_ALL, 0, 8'hff, 8'hff, 8'hff, 0);
    queue_request(CMD_GET, PIXELS - 1, 0, 0, 0, 0);

    // random, biased toward a few hot pixels at each end of the store
    for (int n = 0; n < RANDOM_REQS; n++) begin
      c = $urandom_range(0, 99);
      if (c < 2) op = CMD_FILL;
      else if (c < 3) op = CMD_CLEAR_ALL;
      else op = cmd_e'($urandom_range(int'(CMD_SET), int'(CMD_CLEAR)));
      p = $urandom_range(0, 99);
      if (p < 55) begin
        pos = $urandom_range(0, 7);
        if ($urandom_range(0, 1) == 1) pos = PIXELS - 1 - pos;
      end else if (p < 80) begin
        pos = $urandom_range(0, PIXELS - 1);
      end else if (p < 95) begin
        pos = $urandom_range(PIXELS, 1023);
      end else begin
        pos = $urandom_range(0, 1023);
      end
      queue_request(op, pos, pick_channel(), pick_channel(), pick_channel(),
                    ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 100),
                    (n % 400) == 399);
    end

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || req_valid) @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (PIXELS + 20) @(posedge clk);
    fail_count += expected_colors.size();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
